### rtl/core/snap_pkg.sv
// Shared types and constants of the snapshot record parser.
// Holds the result record, the queue write bundle, result and error codes,
// the magic table and the CRC-32 byte step. No dependencies.
`default_nettype none

package snap_pkg;

  localparam int unsigned MAX_VARINT_BYTES = 10;
  localparam int unsigned Q_DEPTH          = 4;
  localparam int unsigned Q_PTR_W          = $clog2(Q_DEPTH);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [7:0] OP_EXPIRY = 8'hFC;
  localparam logic [7:0] OP_EOF    = 8'hFF;
  localparam logic [7:0] OP_RECORD = 8'h00;
  localparam logic [7:0] VERSION   = 8'h01;

  localparam int unsigned MAGIC_LEN = 6;
  localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h4B, 8'h56, 8'h53, 8'h4E, 8'h41, 8'h50};

  // result kinds
  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_VALUE   = 3'd1;
  localparam logic [2:0] KIND_COMMIT  = 3'd2;
  localparam logic [2:0] KIND_LOAD_OK = 3'd3;
  localparam logic [2:0] KIND_LOAD_ER = 3'd4;

  // outcome codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_VERSION   = 3'd2;
  localparam logic [2:0] ERR_TRUNC     = 3'd3;
  localparam logic [2:0] ERR_NEG_EXP   = 3'd4;
  localparam logic [2:0] ERR_OPCODE    = 3'd5;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd6;
  localparam logic [2:0] ERR_TRAILING  = 3'd7;

  // configuration register index, taken from paddr[3]
  localparam logic CFG_IDX_NOW_TIME = 1'b0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic        has_expiry;
    logic [62:0] expire_time;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;      // number of results written this cycle
    result_t    r0;
    result_t    r1;
  } push_t;

  // Reflected CRC-32 over one byte, pre/post inverted per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/snap_cfg.sv
// APB-style configuration register block: holds now_time.
// Depends on snap_pkg.
`default_nettype none

module snap_cfg import snap_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output logic [62:0]      now_time
);

  logic [62:0] now_time_r;
  logic        sel_now;

  assign pready  = 1'b1;
  assign sel_now = (paddr[3] == CFG_IDX_NOW_TIME);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_time_r <= '0;
    end else if (psel && penable && pwrite && pready && sel_now) begin
      now_time_r <= pwdata[62:0];
    end
  end

  assign prdata   = sel_now ? {1'b0, now_time_r} : 64'd0;
  assign now_time = now_time_r;

endmodule

`default_nettype wire

### rtl/core/snap_parse.sv
// Byte-level parser: phase state, varint lengths, expiry, CRC and trailer.
// Produces up to two results per accepted item. Depends on snap_pkg.
`default_nettype none

module snap_parse import snap_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  file_byte,
  input  wire logic        end_of_file,
  input  wire logic [62:0] now_time,
  output push_t            push
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_OPCODE, PH_EXPIRY, PH_OP2, PH_KEYLEN,
    PH_KEY, PH_VALLEN, PH_VAL, PH_TRAILER, PH_AFTER, PH_DONE
  } phase_t;

  localparam logic [3:0] MAX_IDX = 4'(MAX_VARINT_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_eof_r, crc_eof_nxt;
  logic [63:0] exp_r, exp_nxt;
  logic        has_exp_r, has_exp_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] trl_r, trl_nxt;
  logic        keep_r, keep_nxt;
  logic [2:0]  outcome_r, outcome_nxt;

  logic [31:0] crc_new;
  logic [63:0] len_or, len_dec;
  logic [5:0]  vshift;
  logic [3:0]  idx_inc;
  logic [31:0] trl_new;
  logic        finish;
  logic [2:0]  finish_code;
  result_t     commit_res, outcome_res;
  logic [2:0]  out_code;

  assign crc_new = crc_byte(crc_r, file_byte);
  assign vshift  = 6'(7 * idx_r);
  assign len_or  = len_r | (64'(file_byte[6:0]) << vshift);
  assign len_dec = len_r - 64'd1;
  assign idx_inc = idx_r + 4'd1;
  assign trl_new = trl_r | (32'(file_byte) << {idx_r[1:0], 3'b000});

  always_comb begin
    commit_res             = '0;
    commit_res.kind        = KIND_COMMIT;
    commit_res.has_expiry  = has_exp_r;
    commit_res.expire_time = has_exp_r ? exp_r[62:0] : 63'd0;
  end

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    crc_eof_nxt = crc_eof_r;
    exp_nxt     = exp_r;
    has_exp_nxt = has_exp_r;
    len_nxt     = len_r;
    trl_nxt     = trl_r;
    keep_nxt    = keep_r;
    finish      = 1'b0;
    finish_code = ERR_NONE;
    push        = '0;

    if (phase_r == PH_DONE) begin
      // repeat the outcome
      push.n = 2'd1;
    end else if (end_of_file) begin
      finish = 1'b1;
      if (phase_r == PH_MAGIC) begin
        finish_code = ERR_MAGIC;
      end else if (phase_r == PH_AFTER) begin
        finish_code = ERR_NONE;
      end else begin
        finish_code = ERR_TRUNC;
      end
    end else begin
      crc_nxt = crc_new;
      unique case (phase_r)
        PH_MAGIC: begin
          if (idx_r >= 4'(MAGIC_LEN) || file_byte != MAGIC[idx_r[2:0]]) begin
            finish      = 1'b1;
            finish_code = ERR_MAGIC;
          end else if (idx_inc == 4'(MAGIC_LEN)) begin
            idx_nxt   = '0;
            phase_nxt = PH_VERSION;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        PH_VERSION: begin
          if (file_byte != VERSION) begin
            finish      = 1'b1;
            finish_code = ERR_VERSION;
          end else begin
            phase_nxt = PH_OPCODE;
          end
        end
        PH_OPCODE: begin
          has_exp_nxt = 1'b0;
          exp_nxt     = '0;
          if (file_byte == OP_EXPIRY) begin
            idx_nxt   = '0;
            phase_nxt = PH_EXPIRY;
          end else if (file_byte == OP_EOF) begin
            crc_eof_nxt = crc_new;
            trl_nxt     = '0;
            idx_nxt     = '0;
            phase_nxt   = PH_TRAILER;
          end else if (file_byte == OP_RECORD) begin
            keep_nxt  = 1'b1;
            idx_nxt   = '0;
            len_nxt   = '0;
            phase_nxt = PH_KEYLEN;
          end else begin
            finish      = 1'b1;
            finish_code = ERR_OPCODE;
          end
        end
        PH_EXPIRY: begin
          exp_nxt = exp_r | (64'(file_byte) << {idx_r[2:0], 3'b000});
          if (idx_inc >= 4'd8) begin
            idx_nxt   = '0;
            phase_nxt = PH_OP2;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        PH_OP2: begin
          if (exp_r[63]) begin
            finish      = 1'b1;
            finish_code = ERR_NEG_EXP;
          end else if (file_byte != OP_RECORD) begin
            finish      = 1'b1;
            finish_code = ERR_OPCODE;
          end else begin
            has_exp_nxt = 1'b1;
            keep_nxt    = (exp_r[62:0] > now_time);
            idx_nxt     = '0;
            len_nxt     = '0;
            phase_nxt   = PH_KEYLEN;
          end
        end
        PH_KEYLEN, PH_VALLEN: begin
          len_nxt = len_or;
          if (!file_byte[7]) begin
            idx_nxt = '0;
            if (phase_r == PH_KEYLEN) begin
              phase_nxt = (len_or != 64'd0) ? PH_KEY : PH_VALLEN;
            end else if (len_or != 64'd0) begin
              phase_nxt = PH_VAL;
            end else begin
              push.r0   = commit_res;
              push.n    = keep_r ? 2'd1 : 2'd0;
              phase_nxt = PH_OPCODE;
            end
          end else if (idx_inc >= MAX_IDX) begin
            idx_nxt     = idx_inc;
            finish      = 1'b1;
            finish_code = ERR_TRUNC;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        PH_KEY: begin
          push.r0.kind = KIND_KEY;
          push.r0.data = file_byte;
          push.n       = keep_r ? 2'd1 : 2'd0;
          len_nxt      = len_dec;
          if (len_dec == 64'd0) begin
            idx_nxt   = '0;
            phase_nxt = PH_VALLEN;
          end
        end
        PH_VAL: begin
          // last value byte is followed by the commit
          push.r0.kind = KIND_VALUE;
          push.r0.data = file_byte;
          push.r1      = commit_res;
          len_nxt      = len_dec;
          if (len_dec == 64'd0) begin
            push.n    = keep_r ? 2'd2 : 2'd0;
            phase_nxt = PH_OPCODE;
          end else begin
            push.n    = keep_r ? 2'd1 : 2'd0;
          end
        end
        PH_TRAILER: begin
          trl_nxt = trl_new;
          if (idx_inc >= 4'd4) begin
            idx_nxt = '0;
            if (trl_new != crc_eof_r) begin
              finish      = 1'b1;
              finish_code = ERR_CHECKSUM;
            end else begin
              phase_nxt = PH_AFTER;
            end
          end else begin
            idx_nxt = idx_inc;
          end
        end
        PH_AFTER: begin
          finish      = 1'b1;
          finish_code = ERR_TRAILING;
        end
        default: begin
          finish      = 1'b1;
          finish_code = ERR_TRUNC;
        end
      endcase
    end

    outcome_nxt = outcome_r;
    if (finish) begin
      outcome_nxt = finish_code;
      phase_nxt   = PH_DONE;
      push.n      = 2'd1;
    end
    out_code = finish ? finish_code : outcome_r;

    outcome_res            = '0;
    outcome_res.kind       = (out_code == ERR_NONE) ? KIND_LOAD_OK : KIND_LOAD_ER;
    outcome_res.error_code = out_code;
    if (finish || phase_r == PH_DONE) begin
      push.r0 = outcome_res;
    end

    push.r0.last = (push.n == 2'd1);
    push.r1.last = 1'b1;
    if (!accept) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC;
      idx_r     <= '0;
      crc_r     <= '0;
      crc_eof_r <= '0;
      exp_r     <= '0;
      has_exp_r <= 1'b0;
      len_r     <= '0;
      trl_r     <= '0;
      keep_r    <= 1'b0;
      outcome_r <= ERR_NONE;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      crc_eof_r <= crc_eof_nxt;
      exp_r     <= exp_nxt;
      has_exp_r <= has_exp_nxt;
      len_r     <= len_nxt;
      trl_r     <= trl_nxt;
      keep_r    <= keep_nxt;
      outcome_r <= outcome_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/snap_outq.sv
// Result queue: takes up to two results per cycle, hands out one.
// Depends on snap_pkg.
`default_nettype none

module snap_outq import snap_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_res
);

  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  result_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // keep space for the worst-case two results of the next item
  assign room      = (cnt_r <= CNT_W'(Q_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_r + Q_PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/snapshot_record_parser.sv
// Top level of the snapshot record parser: configuration port, parser and
// result queue. Depends on snap_pkg, snap_cfg, snap_parse, snap_outq.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tdata file_byte, tuser end_of_file
//  out_    | out | out_tvalid / out_tready| tdata, tuser result_kind, tlast
//  cfg_    | in  | APB psel/penable       | now_time at byte address 0
//
// One item is taken per cycle; its results are written to a four-entry queue
// in the same cycle and leave one per cycle from the next. in_tready drops while
// the queue holds more than two results, so a stalled output holds off the input
// after two items that make two results each, or three that make one each.
// Reset is synchronous; no clearing pass follows.
`default_nettype none

module snapshot_record_parser import snap_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] file_byte
  input  wire logic        in_tuser,   // [0] end_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [7:0] data_byte, [8] has_expiry,
                                       // [71:9] expire_time, [74:72] error_code
  output logic [2:0]       out_tuser,  // [2:0] result_kind
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [62:0] now_time;
  logic        accept;
  push_t       push;
  result_t     res;

  snap_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .now_time (now_time)
  );

  assign accept = in_tvalid && in_tready;

  snap_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .file_byte   (in_tdata),
    .end_of_file (in_tuser),
    .now_time    (now_time),
    .push        (push)
  );

  snap_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {5'd0, res.error_code, res.expire_time, res.has_expiry, res.data};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire

### tb/snap_result_checker.sv
// Result checker for the snapshot record parser: follows accepted file items
// and configuration writes, predicts every result and compares each one sent.
// Depends on snap_pkg for the result record, result kinds and error codes.
module snap_result_checker import snap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending,
  output int          results_seen,
  output logic [31:0] file_crc
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 40;

  typedef enum logic [3:0] {
    ST_MAGIC, ST_VERSION, ST_OPCODE, ST_EXPIRY, ST_OP2, ST_KEYLEN, ST_KEY,
    ST_VALLEN, ST_VAL, ST_TRAILER, ST_AFTER, ST_DONE
  } parse_st_t;

  parse_st_t   st;
  int unsigned idx;
  int unsigned item_results;
  logic [31:0] crc;
  logic [31:0] crc_eof;
  logic [31:0] trl;
  logic [63:0] exp_acc;
  logic [63:0] len_left;
  logic        exp_on;
  logic        keep;
  logic [2:0]  outcome;
  logic [62:0] now_t;
  result_t     expected_q[$];

  // bit-serial form of the reflected CRC-32, inverted on entry and exit
  function automatic logic [31:0] crc_step(logic [31:0] crc_in, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = ~crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return ~c;
  endfunction

  function automatic result_t make_res(logic [2:0] kind, logic [7:0] data, logic hx,
                                       logic [62:0] exp_t, logic [2:0] err);
    result_t r;
    r             = '0;
    r.kind        = kind;
    r.data        = data;
    r.has_expiry  = hx;
    r.expire_time = exp_t;
    r.error_code  = err;
    return r;
  endfunction

  task add_result(input result_t r);
    expected_q.push_back(r);
    item_results++;
  endtask

  task add_outcome();
    add_result(make_res(outcome == ERR_NONE ? KIND_LOAD_OK : KIND_LOAD_ER, 8'h00, 1'b0,
                        63'd0, outcome));
  endtask

  task conclude(input logic [2:0] code);
    outcome = code;
    st      = ST_DONE;
    add_outcome();
  endtask

  task commit_record();
    if (keep)
      add_result(make_res(KIND_COMMIT, 8'h00, exp_on, exp_on ? exp_acc[62:0] : 63'd0,
                          ERR_NONE));
  endtask

  task predict_item(input logic [7:0] b, input logic eof);
    int unsigned shamt;
    result_t     tail;
    item_results = 0;
    if (st == ST_DONE) begin
      add_outcome();
    end else if (eof) begin
      conclude(st == ST_MAGIC ? ERR_MAGIC : (st == ST_AFTER ? ERR_NONE : ERR_TRUNC));
    end else begin
      crc = crc_step(crc, b);
      case (st)
        ST_MAGIC: begin
          if (idx >= MAGIC_LEN || b != MAGIC[idx]) begin
            conclude(ERR_MAGIC);
          end else begin
            idx++;
            if (idx == MAGIC_LEN) begin
              idx = 0;
              st  = ST_VERSION;
            end
          end
        end
        ST_VERSION: begin
          if (b != VERSION) conclude(ERR_VERSION);
          else st = ST_OPCODE;
        end
        ST_OPCODE: begin
          exp_on  = 1'b0;
          exp_acc = '0;
          if (b == OP_EXPIRY) begin
            idx = 0;
            st  = ST_EXPIRY;
          end else if (b == OP_EOF) begin
            crc_eof = crc;
            trl     = '0;
            idx     = 0;
            st      = ST_TRAILER;
          end else if (b == OP_RECORD) begin
            keep     = 1'b1;
            idx      = 0;
            len_left = '0;
            st       = ST_KEYLEN;
          end else begin
            conclude(ERR_OPCODE);
          end
        end
        ST_EXPIRY: begin
          exp_acc = exp_acc | (64'(b) << (8 * (idx % 8)));
          idx++;
          if (idx >= 8) begin
            idx = 0;
            st  = ST_OP2;
          end
        end
        ST_OP2: begin
          // the sign of the expiry is only judged once the next opcode is in
          if (exp_acc[63]) begin
            conclude(ERR_NEG_EXP);
          end else if (b != OP_RECORD) begin
            conclude(ERR_OPCODE);
          end else begin
            exp_on   = 1'b1;
            keep     = exp_acc[62:0] > now_t;
            idx      = 0;
            len_left = '0;
            st       = ST_KEYLEN;
          end
        end
        ST_KEYLEN, ST_VALLEN: begin
          shamt = 7 * idx;
          // drop length bits that land above bit 63
          if (shamt < 64) len_left = len_left | (64'(b[6:0]) << shamt);
          if (!b[7]) begin
            idx = 0;
            if (st == ST_KEYLEN) begin
              st = (len_left != 0) ? ST_KEY : ST_VALLEN;
            end else if (len_left != 0) begin
              st = ST_VAL;
            end else begin
              commit_record();
              st = ST_OPCODE;
            end
          end else begin
            idx++;
            if (idx >= MAX_VARINT_BYTES) conclude(ERR_TRUNC);
          end
        end
        ST_KEY: begin
          if (keep) add_result(make_res(KIND_KEY, b, 1'b0, 63'd0, ERR_NONE));
          len_left = len_left - 1;
          if (len_left == 0) begin
            idx = 0;
            st  = ST_VALLEN;
          end
        end
        ST_VAL: begin
          if (keep) add_result(make_res(KIND_VALUE, b, 1'b0, 63'd0, ERR_NONE));
          len_left = len_left - 1;
          if (len_left == 0) begin
            commit_record();
            st = ST_OPCODE;
          end
        end
        ST_TRAILER: begin
          trl = trl | (32'(b) << (8 * (idx % 4)));
          idx++;
          if (idx >= 4) begin
            idx = 0;
            if (trl != crc_eof) conclude(ERR_CHECKSUM);
            else st = ST_AFTER;
          end
        end
        ST_AFTER: conclude(ERR_TRAILING);
        default:  conclude(ERR_TRUNC);
      endcase
    end
    if (item_results > 0) begin
      tail      = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endtask

  task report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (mismatches < MAX_REPORTS)
      $display("mismatch on result %0d: %s is 0x%0h, predicted 0x%0h",
               results_seen, what, got, want);
    mismatches++;
  endtask

  task check_result(input result_t want);
    if (out_tuser !== want.kind) report("result_kind", 64'(out_tuser), 64'(want.kind));
    if (out_tdata[7:0] !== want.data)
      report("data_byte", 64'(out_tdata[7:0]), 64'(want.data));
    if (out_tdata[8] !== want.has_expiry)
      report("has_expiry", 64'(out_tdata[8]), 64'(want.has_expiry));
    if (out_tdata[71:9] !== want.expire_time)
      report("expire_time", 64'(out_tdata[71:9]), 64'(want.expire_time));
    if (out_tdata[74:72] !== want.error_code)
      report("error_code", 64'(out_tdata[74:72]), 64'(want.error_code));
    if (out_tlast !== want.last) report("last_of_item", 64'(out_tlast), 64'(want.last));
    if (out_tdata[79:75] !== 5'd0) report("tdata padding", 64'(out_tdata[79:75]), 64'd0);
  endtask

  initial begin
    mismatches   = 0;
    results_seen = 0;
    pending      = 0;
    file_crc     = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      st       = ST_MAGIC;
      idx      = 0;
      crc      = '0;
      crc_eof  = '0;
      trl      = '0;
      exp_acc  = '0;
      exp_on   = 1'b0;
      len_left = '0;
      keep     = 1'b0;
      outcome  = ERR_NONE;
      now_t    = '0;
      expected_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[3] == CFG_IDX_NOW_TIME)
        now_t = cfg_pwdata[62:0];
      if (in_tvalid && in_tready) predict_item(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) report("unpredicted result, kind", 64'(out_tuser), 64'd0);
        else check_result(expected_q.pop_front());
        results_seen++;
      end
    end
    pending  = expected_q.size();
    file_crc = crc;
  end

endmodule

### tb/tb_snapshot_record_parser.sv
// Testbench top for the snapshot record parser: drives snapshot files byte by
// byte with random idling and back-pressure, sets now_time over the APB port,
// and gives the verdict. Depends on snap_pkg and snap_result_checker.
module tb_snapshot_record_parser import snap_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          IDLE_PCT      = 20;
  localparam int          HOLD_CYCLES   = 64;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          BODY_ITEMS    = 400;
  localparam int          AFTER_ITEMS   = 20;
  localparam int          STALL_LIMIT   = 1000;
  localparam logic [62:0] MAX63         = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [3:0]  ADDR_NOW_TIME = {CFG_IDX_NOW_TIME, 3'b000};

  typedef enum {
    END_OK, END_TRAILING, END_CHECKSUM, END_EOF_EARLY, END_LONG_VARINT,
    END_NEG_EXPIRY, END_BAD_OPCODE, END_BAD_MAGIC, END_EOF_MAGIC, END_BAD_VERSION
  } file_end_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [7:0]  in_tdata    = 8'h00;
  logic        in_tuser    = 1'b0;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = 4'h0;
  logic [63:0] cfg_pwdata  = 64'h0;
  logic        in_tready;
  logic        out_tvalid;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatches;
  int          pending;
  int          results_seen;
  logic [31:0] file_crc;

  bit          calm      = 1'b0;
  int          hold_ask  = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [62:0] now_val   = '0;
  int          items_sent     = 0;
  int          records        = 0;
  int          expiry_records = 0;
  string       end_desc;
  file_end_t   ending;
  logic [7:0]  rec_q[$];

  snapshot_record_parser i_dut (.*);
  snap_result_checker i_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_ask) begin
      hold_seen  = hold_ask;
      hold_left  = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: %0d cycles without any transfer", STALL_LIMIT);
    $display("snapshot_record_parser verification failed");
    $finish;
  end

  // Entered and left just after a falling edge; valid stays high on exit.
  task send_item(input logic [7:0] b, input logic eof);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eof;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task send_queue(input int count);
    for (int i = 0; i < count; i++) send_item(rec_q[i], 1'b0);
  endtask

  task send_trailer(input logic [31:0] sum);
    for (int i = 0; i < 4; i++) send_item(sum[8*i +: 8], 1'b0);
  endtask

  task settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_now(input logic [62:0] val);
    settle();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_NOW_TIME;
    cfg_pwdata  <= {1'b0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    now_val = val;
  endtask

  // Mostly minimal encodings, some padded, some at the full ten bytes with
  // junk in the bits that fall above bit 63.
  function automatic void put_len(int v);
    logic [7:0] b;
    int         minw;
    int         nbytes;
    int         r;
    minw = 1;
    while ((v >> (7 * minw)) != 0) minw++;
    r = $urandom_range(99);
    if (r < 70) nbytes = minw;
    else if (r < 90) nbytes = minw + $urandom_range(2, 1);
    else nbytes = MAX_VARINT_BYTES;
    for (int i = 0; i < nbytes; i++) begin
      b = 8'((v >> (7 * i)) & 'h7F);
      if (i < nbytes - 1) b[7] = 1'b1;
      else if (nbytes == MAX_VARINT_BYTES) b[6:1] = 6'($urandom);
      rec_q.push_back(b);
    end
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(4, 1);
    return $urandom_range(24, 5);
  endfunction

  function automatic logic [62:0] pick_expiry();
    case ($urandom_range(6))
      0:       return now_val;
      1:       return now_val + 63'd1;
      2:       return now_val - 63'd1;
      3:       return 63'd0;
      4:       return MAX63;
      5:       return 63'({$urandom, $urandom});
      default: return now_val + 63'($urandom_range(1000, 1));
    endcase
  endfunction

  function automatic logic [62:0] pick_now();
    case ((records / 8) % 4)
      0:       return MAX63;
      1:       return 63'd0;
      2:       return 63'({$urandom, $urandom});
      default: return 63'($urandom_range(5000));
    endcase
  endfunction

  function automatic void push_expiry(logic [63:0] e);
    rec_q.push_back(OP_EXPIRY);
    for (int i = 0; i < 8; i++) rec_q.push_back(e[8*i +: 8]);
  endfunction

  function automatic void make_record();
    int klen;
    int vlen;
    rec_q.delete();
    if ($urandom_range(1)) begin
      push_expiry({1'b0, pick_expiry()});
      expiry_records++;
    end
    rec_q.push_back(OP_RECORD);
    klen = pick_len();
    put_len(klen);
    repeat (klen) rec_q.push_back(8'($urandom));
    vlen = pick_len();
    put_len(vlen);
    repeat (vlen) rec_q.push_back(8'($urandom));
    records++;
  endfunction

  initial begin : stimulus
    logic [31:0] sum;
    logic [7:0]  junk;
    int          cut;
    int          pick;

    pick = $urandom_range(99);
    if (pick < 22) ending = END_OK;
    else if (pick < 34) ending = END_TRAILING;
    else if (pick < 46) ending = END_CHECKSUM;
    else if (pick < 58) ending = END_EOF_EARLY;
    else if (pick < 68) ending = END_LONG_VARINT;
    else if (pick < 78) ending = END_NEG_EXPIRY;
    else if (pick < 90) ending = END_BAD_OPCODE;
    else if (pick < 94) ending = END_BAD_MAGIC;
    else if (pick < 97) ending = END_EOF_MAGIC;
    else ending = END_BAD_VERSION;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_now(63'd1000);

    if (ending == END_BAD_MAGIC || ending == END_EOF_MAGIC) begin
      cut = $urandom_range(MAGIC_LEN - 1);
      for (int i = 0; i < cut; i++) send_item(MAGIC[i], 1'b0);
      if (ending == END_EOF_MAGIC) begin
        end_desc = "end of file inside the magic";
        send_item(8'($urandom), 1'b1);
      end else begin
        end_desc = "wrong magic byte";
        do junk = 8'($urandom); while (junk == MAGIC[cut]);
        send_item(junk, 1'b0);
      end
    end else if (ending == END_BAD_VERSION) begin
      end_desc = "wrong version byte";
      for (int i = 0; i < MAGIC_LEN; i++) send_item(MAGIC[i], 1'b0);
      do junk = 8'($urandom); while (junk == VERSION);
      send_item(junk, 1'b0);
    end else begin
      for (int i = 0; i < MAGIC_LEN; i++) send_item(MAGIC[i], 1'b0);
      send_item(VERSION, 1'b0);
      // key 0x00, value 0xFF
      send_item(OP_RECORD, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'hFF, 1'b0);
      // empty key through a padded length, empty value
      send_item(OP_RECORD, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b0);
      // largest expiry, empty key and value
      send_item(OP_EXPIRY, 1'b0);
      repeat (7) send_item(8'hFF, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(OP_RECORD, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b0);

      while (items_sent < BODY_ITEMS) begin
        if (records % 8 == 7) write_now(pick_now());
        calm = (records >= 12 && records < 20);
        if (records % 10 == 4) hold_ask++;
        make_record();
        send_queue(rec_q.size());
      end
      calm = 1'b0;

      case (ending)
        END_OK, END_TRAILING, END_CHECKSUM: begin
          send_item(OP_EOF, 1'b0);
          sum = file_crc;
          if (ending == END_CHECKSUM) begin
            end_desc = "checksum mismatch";
            sum = sum ^ (32'd1 << $urandom_range(31));
          end
          send_trailer(sum);
          if (ending == END_TRAILING) begin
            end_desc = "byte after the trailer";
            send_item(8'($urandom), 1'b0);
          end else if (ending == END_OK) begin
            end_desc = "clean load";
            send_item(8'($urandom), 1'b1);
          end
        end
        END_EOF_EARLY: begin
          end_desc = "end of file before the trailer completes";
          if ($urandom_range(1)) begin
            make_record();
            send_queue($urandom_range(rec_q.size() - 1));
          end else begin
            send_item(OP_EOF, 1'b0);
            repeat ($urandom_range(3)) send_item(8'($urandom), 1'b0);
          end
          send_item(8'($urandom), 1'b1);
        end
        END_LONG_VARINT: begin
          end_desc = "over-long length";
          send_item(OP_RECORD, 1'b0);
          if ($urandom_range(1)) send_item(8'h00, 1'b0);
          repeat (MAX_VARINT_BYTES) send_item(8'h80 | 8'($urandom), 1'b0);
        end
        END_NEG_EXPIRY: begin
          end_desc = "expiry with the sign bit set";
          rec_q.delete();
          push_expiry({1'b1, 63'({$urandom, $urandom})});
          rec_q.push_back(8'($urandom));
          send_queue(rec_q.size());
        end
        default: begin
          end_desc = "unknown opcode";
          if ($urandom_range(1)) begin
            rec_q.delete();
            push_expiry({1'b0, pick_expiry()});
            if ($urandom_range(1)) begin
              rec_q.push_back(OP_EOF);
            end else begin
              do junk = 8'($urandom); while (junk == OP_RECORD);
              rec_q.push_back(junk);
            end
            send_queue(rec_q.size());
          end else begin
            do junk = 8'($urandom);
            while (junk == OP_RECORD || junk == OP_EXPIRY || junk == OP_EOF);
            send_item(junk, 1'b0);
          end
        end
      endcase
    end

    // the outcome repeats for anything that follows
    if (records == 0) hold_ask++;
    repeat (AFTER_ITEMS) send_item(8'($urandom), $urandom_range(3) == 0);
    // a file that failed early goes on with repeated outcomes
    while (items_sent < BODY_ITEMS + AFTER_ITEMS) begin
      calm = (items_sent >= 100 && items_sent < 200);
      send_item(8'($urandom), $urandom_range(3) == 0);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d file items, %0d random records (%0d with expiry), %0d results",
             items_sent, records, expiry_records, results_seen);
    $display("file ending: %s", end_desc);
    if (mismatches == 0)
      $display("snapshot_record_parser verification clean");
    else
      $display("snapshot_record_parser verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/snap_pkg.sv
rtl/core/snap_cfg.sv
rtl/core/snap_parse.sv
rtl/core/snap_outq.sv
rtl/core/snapshot_record_parser.sv
tb/snap_result_checker.sv
tb/tb_snapshot_record_parser.sv
